// ----- hdl/rxle_pkg.sv -----
package rxle_pkg;

    // Default ring geometry.
    localparam int RING_LINES_DEF = 8;
    localparam int LINE_BYTES_DEF = 64;

    // Field widths fixed by the stream format.
    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 6;
    localparam int OLEN_W    = 6;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int M_PAD_W   = M_TDATA_W - (BYTE_W + BYTE_W + OLEN_W + 1 + STAT_W);

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_RX      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOPEND = 2'd2;

    // Control characters.
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
    localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOOKUP,
        S_EMIT
    } state_t;

    // Echo run produced by one request.
    typedef enum logic [1:0] {
        ECHO_NONE,
        ECHO_CHAR,
        ECHO_EOL,
        ECHO_ERASE
    } echo_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       exec;
        logic       lookup;
        logic       emit;
        logic [1:0] k;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       out_free;
        logic [1:0] n_results;
    } dp_stat_t;

endpackage

// ----- hdl/rx_line_editor_ring.sv -----
// Receive line editor with terminal echo over a ring of RING_LINES line
// buffers of LINE_BYTES bytes each. A request of kind 0 edits the open line
// (CR or LF closes it and echoes CR LF, backspace on a non-empty line erases
// and echoes BS SP BS, other bytes append and echo unless the line is full),
// kind 1 reads one byte of the oldest closed line and kind 2 releases that
// line. Each request yields one to three results, the last one marked by
// m_tlast; m_tuser says the result carries an echo byte. One request at a
// time is handled: accept, line update, registered read of the byte store
// and the length memory, then one result per cycle into the output register
// while the output slot is free. The final result may still wait in the
// output register while the next request is accepted. A full ring is not
// detected: closing a line onto the oldest one discards the pending lines.
module rx_line_editor_ring import rxle_pkg::*; #(
    parameter int RING_LINES = RING_LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // rx_byte[7:0], read_index[13:8], zero[15:14]
    input  logic [KIND_W-1:0]    s_tuser,   // kind[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // echo_char[7:0], read_data[15:8],
                                            // oldest_length[21:16], line_pending[22],
                                            // status[24:23], zero[31:25]
    output logic                 m_tuser,   // echo_valid
    output logic                 m_tlast    // last
);

    dp_cmd_t  cmd;
    dp_stat_t st;

    // Request sequencer.
    rxle_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .st      (st),
        .cmd     (cmd)
    );

    // Line store, ring pointers and output register.
    rxle_dp #(
        .RING_LINES(RING_LINES),
        .LINE_BYTES(LINE_BYTES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .st      (st),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ----- hdl/rxle_ram.sv -----
module rxle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/rxle_ctrl.sv -----
module rxle_ctrl import rxle_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t st,
    output dp_cmd_t  cmd
);

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;

    // State and result counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // Sequence: take a request, update the line state, read the memories,
    // then hand out one result per free output slot.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.k      = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_LOOKUP;
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (k_reg == st.n_results - 2'd1)
                    begin
                        k_next     = 2'd0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/rxle_dp.sv -----
module rxle_dp import rxle_pkg::*; #(
    parameter int RING_LINES = RING_LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             st,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int LINE_W = $clog2(RING_LINES);
    localparam int LEN_W  = $clog2(LINE_BYTES);
    localparam int DEPTH  = RING_LINES * LINE_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (LEN_W > IDX_W) ? LEN_W : IDX_W;
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(RING_LINES - 1);
    localparam logic [LEN_W-1:0]  FULL_LEN  = LEN_W'(LINE_BYTES - 1);

    // Request fields.
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [IDX_W-1:0]  idx_reg;

    // Ring pointers, length of the line being edited, request outcome.
    logic [LINE_W-1:0] wr_line_reg, wr_line_next;
    logic [LINE_W-1:0] rd_line_reg, rd_line_next;
    logic [LEN_W-1:0]  cur_len_reg, cur_len_next;
    logic [STAT_W-1:0] status_reg, status_next;
    echo_t             echo_reg, echo_next;

    // Output register.
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                 out_user_reg, out_user_next;
    logic                 out_last_reg, out_last_next;

    logic              is_eol, is_bs, is_full, pending;
    logic [LINE_W-1:0] wr_inc, rd_inc;
    logic              store_we, len_we;
    logic [ADDR_W-1:0] store_waddr, store_raddr;
    logic [BYTE_W-1:0] store_rdata;
    logic [LEN_W-1:0]  len_rdata;
    logic              hit;
    logic [BYTE_W-1:0] read_data, echo_char;
    logic [OLEN_W-1:0] olen;
    logic [1:0]        n_results;

    function automatic logic [ADDR_W-1:0] line_addr(input logic [LINE_W-1:0] line,
                                                    input logic [ADDR_W-1:0] pos);
        return ADDR_W'(int'(line) * LINE_BYTES) + pos;
    endfunction

    // Capture the request.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= s_tuser;
            byte_reg <= s_tdata[BYTE_W-1:0];
            idx_reg  <= s_tdata[BYTE_W +: IDX_W];
        end
    end

    // Character classes and ring arithmetic.
    assign is_eol  = (byte_reg == CH_CR) || (byte_reg == CH_LF);
    assign is_bs   = (byte_reg == CH_BS);
    assign is_full = (cur_len_reg >= FULL_LEN);
    assign pending = (wr_line_reg != rd_line_reg);
    assign wr_inc  = (wr_line_reg == LAST_LINE) ? '0 : wr_line_reg + 1'b1;
    assign rd_inc  = (rd_line_reg == LAST_LINE) ? '0 : rd_line_reg + 1'b1;

    // Line editing and release.
    always_comb
    begin
        wr_line_next = wr_line_reg;
        rd_line_next = rd_line_reg;
        cur_len_next = cur_len_reg;
        status_next  = status_reg;
        echo_next    = echo_reg;
        if (cmd.exec)
        begin
            status_next = STAT_OK;
            echo_next   = ECHO_NONE;
            case (kind_reg)
                KIND_RX:
                begin
                    if (is_eol)
                    begin
                        echo_next    = ECHO_EOL;
                        wr_line_next = wr_inc;
                        cur_len_next = '0;
                    end
                    else if (is_bs)
                    begin
                        if (cur_len_reg != '0)
                        begin
                            echo_next    = ECHO_ERASE;
                            cur_len_next = cur_len_reg - 1'b1;
                        end
                    end
                    else if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        echo_next    = ECHO_CHAR;
                        cur_len_next = cur_len_reg + 1'b1;
                    end
                end
                KIND_RELEASE:
                begin
                    if (pending)
                    begin
                        rd_line_next = rd_inc;
                    end
                    else
                    begin
                        status_next = STAT_NOPEND;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_line_reg <= '0;
            rd_line_reg <= '0;
            cur_len_reg <= '0;
        end
        else
        begin
            wr_line_reg <= wr_line_next;
            rd_line_reg <= rd_line_next;
            cur_len_reg <= cur_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        echo_reg   <= echo_next;
    end

    // Byte store: appended bytes go in during the update step.
    assign store_we    = cmd.exec && (kind_reg == KIND_RX) && !is_eol && !is_bs && !is_full;
    assign store_waddr = line_addr(wr_line_reg, ADDR_W'(cur_len_reg));
    assign store_raddr = line_addr(rd_line_reg, ADDR_W'(idx_reg));

    rxle_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (store_we),
        .waddr(store_waddr),
        .wdata(byte_reg),
        .re   (cmd.lookup),
        .raddr(store_raddr),
        .rdata(store_rdata)
    );

    // Length of each closed line, written when the line is closed. Only the
    // lengths of pending lines are ever used, and each was written on closing.
    assign len_we = cmd.exec && (kind_reg == KIND_RX) && is_eol;

    rxle_ram #(
        .WIDTH(LEN_W),
        .DEPTH(RING_LINES)
    ) u_lengths (
        .clk  (clk),
        .we   (len_we),
        .waddr(wr_line_reg),
        .wdata(cur_len_reg),
        .re   (cmd.lookup),
        .raddr(rd_line_reg),
        .rdata(len_rdata)
    );

    // Summary fields shared by all results of the request.
    assign hit       = (kind_reg == KIND_READ) && pending
                       && (CMP_W'(idx_reg) < CMP_W'(len_rdata));
    assign read_data = hit ? store_rdata : '0;
    assign olen      = pending ? OLEN_W'(len_rdata) : '0;

    // Number of results and the echo byte of result k.
    always_comb
    begin
        case (echo_reg)
            ECHO_EOL:   n_results = 2'd2;
            ECHO_ERASE: n_results = 2'd3;
            default:    n_results = 2'd1;
        endcase
    end

    always_comb
    begin
        case (echo_reg)
            ECHO_CHAR:  echo_char = byte_reg;
            ECHO_EOL:   echo_char = (cmd.k == 2'd0) ? CH_CR : CH_LF;
            ECHO_ERASE: echo_char = (cmd.k == 2'd1) ? CH_SP : CH_BS;
            default:    echo_char = '0;
        endcase
    end

    assign out_data_next = {{M_PAD_W{1'b0}}, status_reg, pending, olen, read_data, echo_char};
    assign out_user_next = (echo_reg != ECHO_NONE);
    assign out_last_next = (cmd.k == n_results - 2'd1);

    // Output register: loaded when the slot is free, cleared when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= out_last_next;
        end
    end

    assign st.out_free  = !out_valid_reg || m_tready;
    assign st.n_results = n_results;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hdl/rxle_checker.sv -----
module rxle_checker import rxle_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // A result without an echo byte is the only result of its request.
    a_noecho_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[7:0] == 8'h00)))
        else $error("result without echo is not a lone last result");

    // A dropped byte or an empty release produces no echo.
    a_error_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[24:23] != STAT_OK)) |-> (m_tlast && !m_tuser))
        else $error("error status on an echo result");

    // With nothing pending the oldest length reads zero.
    a_no_line_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[22]) |-> (m_tdata[21:16] == 6'd0))
        else $error("oldest length nonzero with no line pending");

    // No new request is taken while an echo run is still being delivered.
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !(s_tvalid && s_tready))
        else $error("request accepted in the middle of a result run");

    // Once a non-final result is taken, the next result of the run is
    // loaded at the same edge and shows up right away.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("result run broken after a non-final result");

endmodule

bind rx_line_editor_ring rxle_checker u_rxle_checker (.*);
